// File: rtl/core/pwft_pkg.sv
package pwft_pkg;

	// Frame shape
	localparam int DATA_BITS  = 8;
	localparam int CHECK_BITS = 4;

	// Field and state widths
	localparam int BYTE_W     = 8;
	localparam int ONES_W     = 4;
	localparam int TICK_W     = 8;
	localparam int IDX_W      = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_W      = 8;
	localparam int PULSES_W   = 5;
	localparam int SHORT_W    = 4;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 8;

	// Register reset values
	localparam logic [TICK_W-1:0]   LEAD_GAP_RST   = 8'd80;
	localparam logic [TICK_W-1:0]   TAIL_GAP_RST   = 8'd6;
	localparam logic [PULSES_W-1:0] PRE_PULSES_RST = 5'd16;
	localparam logic [SHORT_W-1:0]  PRE_HALF_RST   = 4'd1;
	localparam logic [SHORT_W-1:0]  ZERO_HIGH_RST  = 4'd2;
	localparam logic [SHORT_W-1:0]  ONE_HIGH_RST   = 4'd4;
	localparam logic [SHORT_W-1:0]  BIT_LOW_RST    = 4'd2;

	typedef enum logic [0:0] {
		REQ_TICK  = 1'b0,
		REQ_START = 1'b1
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LEAD_GAP   = 3'd0,
		CFG_TAIL_GAP   = 3'd1,
		CFG_PRE_PULSES = 3'd2,
		CFG_PRE_HALF   = 3'd3,
		CFG_ZERO_HIGH  = 3'd4,
		CFG_ONE_HIGH   = 3'd5,
		CFG_BIT_LOW    = 3'd6
	} cfg_idx_t;

	typedef enum logic [5:0] {
		PH_IDLE  = 6'b000001,
		PH_LEAD  = 6'b000010,
		PH_PRE   = 6'b000100,
		PH_DATA  = 6'b001000,
		PH_CHECK = 6'b010000,
		PH_TAIL  = 6'b100000
	} phase_t;

	// Classified item as it travels from front to back
	typedef struct packed {
		req_t              kind;
		logic [BYTE_W-1:0] data;
		logic [ONES_W-1:0] ones;
	} item_t;

	// Count set bits of a byte
	function automatic logic [ONES_W-1:0] popcount(input logic [BYTE_W-1:0] d);
		logic [ONES_W-1:0] n;
		n = '0;
		for (int i = 0; i < BYTE_W; i++) begin
			n = n + {{(ONES_W-1){1'b0}}, d[i]};
		end
		return n;
	endfunction

endpackage

// File: rtl/core/pwft_front.sv
module pwft_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  pwft_pkg::req_t               in_kind,
	input  logic [pwft_pkg::BYTE_W-1:0]  in_data,
	input  logic                         q_full,
	output logic                         push,
	output pwft_pkg::item_t              push_item
);
	import pwft_pkg::*;

	logic  valid_s1;
	item_t item_s1;

	// Stage is free when empty or draining into the queue this cycle
	assign in_ready  = !valid_s1 || !q_full;
	assign push      = valid_s1 && !q_full;
	assign push_item = item_s1;

	// Hold stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// Classify beat and count set bits of the byte
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.kind <= in_kind;
			item_s1.data <= in_data;
			item_s1.ones <= popcount(in_data);
		end
	end

endmodule

// File: rtl/core/pwft_queue.sv
module pwft_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pwft_pkg::item_t push_item,
	output logic            full,
	output logic            q_valid,
	input  logic            pop,
	output pwft_pkg::item_t pop_item
);
	import pwft_pkg::*;

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign q_valid  = (count_q != '0);
	assign pop_item = mem_q[rd_ptr_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// File: rtl/core/pwft_back.sv
module pwft_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pwft_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pwft_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           q_valid,
	input  pwft_pkg::item_t                pop_item,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [pwft_pkg::OUT_TDATA_W-1:0] out_data,
	output logic                           out_last
);
	import pwft_pkg::*;

	localparam int LIM_W = IDX_W + 1;
	localparam logic [LIM_W-1:0] DATA_LIM  = LIM_W'(DATA_BITS);
	localparam logic [LIM_W-1:0] CHECK_LIM = LIM_W'(CHECK_BITS);

	typedef struct packed {
		logic line_level;
		logic indicator;
		logic busy_res;
		logic frame_done;
		logic start_accepted;
	} res_t;

	// Configuration registers
	logic [TICK_W-1:0]   lead_gap_q;
	logic [TICK_W-1:0]   tail_gap_q;
	logic [PULSES_W-1:0] pre_pulses_q;
	logic [SHORT_W-1:0]  pre_half_q;
	logic [SHORT_W-1:0]  zero_high_q;
	logic [SHORT_W-1:0]  one_high_q;
	logic [SHORT_W-1:0]  bit_low_q;

	// Frame state
	phase_t            phase_q, phase_n;
	logic [TICK_W-1:0] tick_q, tick_n;
	logic [IDX_W-1:0]  bit_q, bit_n;
	logic [BYTE_W-1:0] shift_q, shift_n;
	logic [ONES_W-1:0] ones_q, ones_n;
	logic              ind_q, ind_n;
	logic              pulse_q, pulse_n;

	// Output register
	logic out_valid_q;
	res_t res_q, res_n;

	logic              pulse_ph;
	logic              cur_bit;
	logic [TICK_W-1:0] len;
	logic [TICK_W-1:0] len_eff;
	logic [TICK_W-1:0] tick_inc;
	logic [LIM_W-1:0]  bit_inc;
	logic [LIM_W-1:0]  limit;
	phase_t            next_ph;

	assign pop       = q_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = {{(OUT_TDATA_W-4){1'b0}}, res_q.start_accepted, res_q.busy_res,
		res_q.indicator, res_q.line_level};
	assign out_last  = res_q.frame_done;

	assign pulse_ph = (phase_q == PH_PRE) || (phase_q == PH_DATA) || (phase_q == PH_CHECK);

	// Pick the bit on the line and the length of the current segment
	always_comb begin
		if (phase_q == PH_DATA) begin
			cur_bit = (bit_q < IDX_W'(BYTE_W)) ? shift_q[bit_q[$clog2(BYTE_W)-1:0]] : 1'b0;
		end else begin
			cur_bit = (bit_q < IDX_W'(ONES_W)) ? ones_q[bit_q[$clog2(ONES_W)-1:0]] : 1'b0;
		end
		case (phase_q)
			PH_LEAD: len = lead_gap_q;
			PH_TAIL: len = tail_gap_q;
			PH_PRE:  len = {{(TICK_W-SHORT_W){1'b0}}, pre_half_q};
			PH_DATA, PH_CHECK: begin
				if (!pulse_q) begin
					len = {{(TICK_W-SHORT_W){1'b0}}, bit_low_q};
				end else if (cur_bit) begin
					len = {{(TICK_W-SHORT_W){1'b0}}, one_high_q};
				end else begin
					len = {{(TICK_W-SHORT_W){1'b0}}, zero_high_q};
				end
			end
			default: len = TICK_W'(1);
		endcase
		len_eff  = (len == '0) ? TICK_W'(1) : len;
		tick_inc = tick_q + 1'b1;
		bit_inc  = {1'b0, bit_q} + 1'b1;
		case (phase_q)
			PH_PRE: begin
				limit   = {1'b0, pre_pulses_q};
				next_ph = PH_DATA;
			end
			PH_DATA: begin
				limit   = DATA_LIM;
				next_ph = PH_CHECK;
			end
			default: begin
				limit   = CHECK_LIM;
				next_ph = PH_TAIL;
			end
		endcase
	end

	// Carry out one item
	always_comb begin
		phase_n = phase_q;
		tick_n  = tick_q;
		bit_n   = bit_q;
		shift_n = shift_q;
		ones_n  = ones_q;
		ind_n   = ind_q;
		pulse_n = pulse_q;
		res_n   = res_q;
		if (pop) begin
			res_n = '0;
			if (pop_item.kind == REQ_START) begin
				res_n.busy_res = 1'b1;
				if (phase_q == PH_IDLE) begin
					shift_n = pop_item.data;
					ones_n  = pop_item.ones;
					phase_n = PH_LEAD;
					tick_n  = '0;
					bit_n   = '0;
					pulse_n = 1'b0;
					ind_n   = 1'b0;
					res_n.start_accepted = 1'b1;
				end else begin
					res_n.line_level = pulse_ph && pulse_q;
					res_n.indicator  = ind_q;
				end
			end else if (phase_q != PH_IDLE) begin
				res_n.busy_res   = 1'b1;
				res_n.line_level = pulse_ph && pulse_q;
				ind_n = ind_q ^ (pulse_ph && pulse_q && (tick_q == '0));
				if (tick_inc >= len_eff) begin
					tick_n = '0;
					case (phase_q)
						PH_LEAD: begin
							phase_n = PH_PRE;
							bit_n   = '0;
							pulse_n = 1'b1;
						end
						PH_PRE, PH_DATA, PH_CHECK: begin
							if (pulse_q) begin
								pulse_n = 1'b0;
							end else if (bit_inc >= limit) begin
								phase_n = next_ph;
								bit_n   = '0;
								pulse_n = (next_ph != PH_TAIL);
							end else begin
								bit_n   = bit_inc[IDX_W-1:0];
								pulse_n = 1'b1;
							end
						end
						default: res_n.frame_done = 1'b1;
					endcase
				end else begin
					tick_n = tick_inc;
				end
				res_n.indicator = ind_n;
				// Drop back to idle after the closing tick
				if (res_n.frame_done) begin
					phase_n = PH_IDLE;
					ind_n   = 1'b0;
					pulse_n = 1'b0;
					bit_n   = '0;
				end
			end else begin
				res_n.indicator = ind_q;
			end
		end
	end

	// Frame state and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			tick_q      <= '0;
			bit_q       <= '0;
			shift_q     <= '0;
			ones_q      <= '0;
			ind_q       <= 1'b0;
			pulse_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_n;
			tick_q  <= tick_n;
			bit_q   <= bit_n;
			shift_q <= shift_n;
			ones_q  <= ones_n;
			ind_q   <= ind_n;
			pulse_q <= pulse_n;
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold result until taken
	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_n;
		end
	end

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_gap_q   <= LEAD_GAP_RST;
			tail_gap_q   <= TAIL_GAP_RST;
			pre_pulses_q <= PRE_PULSES_RST;
			pre_half_q   <= PRE_HALF_RST;
			zero_high_q  <= ZERO_HIGH_RST;
			one_high_q   <= ONE_HIGH_RST;
			bit_low_q    <= BIT_LOW_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_LEAD_GAP:   lead_gap_q   <= cfg_data[TICK_W-1:0];
				CFG_TAIL_GAP:   tail_gap_q   <= cfg_data[TICK_W-1:0];
				CFG_PRE_PULSES: pre_pulses_q <= cfg_data[PULSES_W-1:0];
				CFG_PRE_HALF:   pre_half_q   <= cfg_data[SHORT_W-1:0];
				CFG_ZERO_HIGH:  zero_high_q  <= cfg_data[SHORT_W-1:0];
				CFG_ONE_HIGH:   one_high_q   <= cfg_data[SHORT_W-1:0];
				CFG_BIT_LOW:    bit_low_q    <= cfg_data[SHORT_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/core/pulse_width_frame_transmitter_core.sv
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser req_type, tdata data_byte
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata line/indicator/busy/start, tlast done
// cfg       in   cfg_we                        cfg_index, cfg_data
//
// One beat per clock is sustained in both directions while m_axis_tready stays high;
// each input beat gives one output beat. An accepted beat passes the classify stage,
// a queue entry and the output register before it is offered on m_axis.
// The frame sequencer in the back part does all its work for a beat in the pop cycle.
// Reset clears frame state, queue and valids, and loads register defaults.
// Output stall backs up through the queue to s_axis_tready without losing a beat.
module pulse_width_frame_transmitter_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [pwft_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic                             s_axis_tuser,  // [0] req_type
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [pwft_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [0] line_level, [1] indicator,
	                                                         // [2] busy_res, [3] start_accepted
	output logic                             m_axis_tlast,  // frame_done
	input  logic                             cfg_we,
	input  logic [pwft_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pwft_pkg::CFG_W-1:0]       cfg_data
);
	import pwft_pkg::*;

	logic  q_full;
	logic  push;
	item_t push_item;
	logic  q_valid;
	logic  pop;
	item_t pop_item;

	pwft_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_kind   (req_t'(s_axis_tuser)),
		.in_data   (s_axis_tdata[BYTE_W-1:0]),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	pwft_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.q_valid   (q_valid),
		.pop       (pop),
		.pop_item  (pop_item)
	);

	pwft_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.pop_item  (pop_item),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

// File: rtl/core/pwft_checker.sv
module pwft_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [pwft_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                             m_axis_tlast
);
	// Stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output beat changed while stalled");

	// Frame end is only reported while busy, with the line low
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[2] && !m_axis_tdata[0])
		else $error("frame end without busy or with line high");

	// A latched start opens the lead gap: line low, indicator cleared, no end mark
	a_start_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[3] |->
		m_axis_tdata[2] && !m_axis_tdata[1] && !m_axis_tdata[0] && !m_axis_tlast)
		else $error("accepted start with wrong line state");

	// Line high means a frame is running
	a_line_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[2])
		else $error("line high while idle");
endmodule

bind pulse_width_frame_transmitter_core pwft_checker u_pwft_checker (.*);

// File: verif/pulse_width_frame_transmitter_core_test.sv
`timescale 1ns / 100ps

module pulse_width_frame_transmitter_core_test;
	import pwft_pkg::*;

	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 6;
	localparam int MAX_REPORTS  = 40;

	// One line beat as the block reports it
	typedef struct packed {
		logic line_level;
		logic indicator;
		logic busy;
		logic frame_done;
		logic start_accepted;
	} line_beat_t;

	logic                   clk;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [7:0] data_byte
	logic                   s_axis_tuser  = REQ_TICK; // [0] req_type
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;  // [0] line, [1] indicator, [2] busy, [3] start_accepted
	logic                   m_axis_tlast;  // [0] frame_done
	logic                   cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index     = CFG_LEAD_GAP;
	logic [CFG_W-1:0]       cfg_data      = '0;

	// Frame sequencer copy: timing registers
	logic [TICK_W-1:0]   lead_gap   = LEAD_GAP_RST;
	logic [TICK_W-1:0]   tail_gap   = TAIL_GAP_RST;
	logic [PULSES_W-1:0] pre_pulses = PRE_PULSES_RST;
	logic [SHORT_W-1:0]  pre_half   = PRE_HALF_RST;
	logic [SHORT_W-1:0]  zero_high  = ZERO_HIGH_RST;
	logic [SHORT_W-1:0]  one_high   = ONE_HIGH_RST;
	logic [SHORT_W-1:0]  bit_low    = BIT_LOW_RST;

	// Frame sequencer copy: frame state
	phase_t            tx_phase = PH_IDLE;
	logic [TICK_W-1:0] tx_ticks = '0;
	logic [IDX_W-1:0]  tx_bit   = '0;
	logic [BYTE_W-1:0] tx_shift = '0;
	logic [ONES_W-1:0] tx_ones  = '0;
	logic              tx_ind   = 1'b0;
	logic              tx_high  = 1'b0;

	line_beat_t line_beats_due[$];
	line_beat_t beat_seen;
	line_beat_t beat_due;

	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	int quiet_cycles   = 0;
	int mismatches     = 0;
	int items_sent     = 0;
	int results_checked = 0;
	int frames_started = 0;
	int starts_ignored = 0;
	int settings_used  = 0;

	pulse_width_frame_transmitter_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic pulsing();
		return (tx_phase == PH_PRE) || (tx_phase == PH_DATA) || (tx_phase == PH_CHECK);
	endfunction

	// Bit on the line in the data or check segment; bits past the field go out as 0
	function automatic logic current_bit();
		logic [BYTE_W-1:0] sh;
		logic [ONES_W-1:0] oc;
		sh = tx_shift >> tx_bit;
		oc = tx_ones >> tx_bit;
		if (tx_phase == PH_DATA) return (tx_bit < DATA_BITS) ? sh[0] : 1'b0;
		return (tx_bit < CHECK_BITS) ? oc[0] : 1'b0;
	endfunction

	// Length in ticks of the segment now on the line
	function automatic logic [TICK_W-1:0] segment_ticks();
		case (tx_phase)
			PH_LEAD: return lead_gap;
			PH_TAIL: return tail_gap;
			PH_PRE:  return TICK_W'(pre_half);
			PH_DATA, PH_CHECK: begin
				if (!tx_high) return TICK_W'(bit_low);
				return current_bit() ? TICK_W'(one_high) : TICK_W'(zero_high);
			end
			default: return TICK_W'(1);
		endcase
	endfunction

	// Move to the next pulse, or on to the following segment once count pulses went out
	function automatic void advance_bit(input int count, input phase_t after);
		tx_bit = tx_bit + 1'b1;
		if (count == 0 || tx_bit >= count || tx_bit == 0) begin
			tx_phase = after;
			tx_bit   = '0;
			tx_high  = (after != PH_TAIL);
		end else begin
			tx_high = 1'b1;
		end
	endfunction

	// Advance the sequencer copy by one accepted beat and return the line beat it gives
	function automatic line_beat_t step_frame(input req_t kind, input logic [BYTE_W-1:0] data);
		line_beat_t beat;
		logic [TICK_W-1:0] span;
		beat = '0;
		if (kind == REQ_START) begin
			if (tx_phase == PH_IDLE) begin
				tx_shift = data;
				tx_ones  = ONES_W'($countones(data));
				tx_phase = PH_LEAD;
				tx_ticks = '0;
				tx_bit   = '0;
				tx_high  = 1'b0;
				tx_ind   = 1'b0;
				beat.start_accepted = 1'b1;
			end
			beat.line_level = pulsing() && tx_high;
			beat.indicator  = tx_ind;
			beat.busy       = 1'b1;
			return beat;
		end
		beat.busy = (tx_phase != PH_IDLE);
		if (beat.busy) begin
			span = segment_ticks();
			if (span == '0) span = TICK_W'(1);
			// toggle the light on the first tick of every pulse
			if (pulsing() && tx_high && tx_ticks == 0) tx_ind = ~tx_ind;
			beat.line_level = pulsing() && tx_high;
			tx_ticks = tx_ticks + 1'b1;
			if (tx_ticks >= span) begin
				tx_ticks = '0;
				case (tx_phase)
					PH_LEAD: begin
						tx_phase = PH_PRE;
						tx_bit   = '0;
						tx_high  = 1'b1;
					end
					PH_PRE: begin
						if (tx_high) tx_high = 1'b0;
						else advance_bit(int'(pre_pulses), PH_DATA);
					end
					PH_DATA: begin
						if (tx_high) tx_high = 1'b0;
						else advance_bit(DATA_BITS, PH_CHECK);
					end
					PH_CHECK: begin
						if (tx_high) tx_high = 1'b0;
						else advance_bit(CHECK_BITS, PH_TAIL);
					end
					default: beat.frame_done = 1'b1;
				endcase
			end
		end
		beat.indicator = tx_ind;
		// drop back to idle after the closing tick
		if (beat.frame_done) begin
			tx_phase = PH_IDLE;
			tx_ind   = 1'b0;
			tx_high  = 1'b0;
			tx_bit   = '0;
		end
		return beat;
	endfunction

	task automatic check_field(input string name, input logic want, input logic got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s mismatch at result %0d: expected %0b, actual %0b",
					$time, name, results_checked, want, got);
		end
	endtask

	// Offer one beat, wait for the handshake, then book its expected line beat
	task automatic send_beat(input req_t kind, input logic [BYTE_W-1:0] data);
		line_beat_t beat;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= data;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		beat = step_frame(kind, data);
		line_beats_due.push_back(beat);
		items_sent++;
		if (kind == REQ_START) begin
			if (beat.start_accepted) frames_started++;
			else starts_ignored++;
		end
	endtask

	// Stop sending and let every booked beat come out
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (line_beats_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all timing registers while the block sits idle
	task automatic program_timing(input logic [7:0] lead_v, input logic [7:0] tail_v,
		input logic [7:0] pulses_v, input logic [7:0] half_v, input logic [7:0] zero_v,
		input logic [7:0] one_v, input logic [7:0] low_v);
		logic [CFG_W-1:0] vals [7];
		cfg_idx_t idx;
		vals[0] = lead_v;
		vals[1] = tail_v;
		vals[2] = pulses_v;
		vals[3] = half_v;
		vals[4] = zero_v;
		vals[5] = one_v;
		vals[6] = low_v;
		drain_results();
		for (int i = 0; i < 7; i++) begin
			idx = cfg_idx_t'(i);
			cfg_we    <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= vals[i];
			@(posedge clk);
			case (idx)
				CFG_LEAD_GAP:   lead_gap   = vals[i];
				CFG_TAIL_GAP:   tail_gap   = vals[i];
				CFG_PRE_PULSES: pre_pulses = vals[i][PULSES_W-1:0];
				CFG_PRE_HALF:   pre_half   = vals[i][SHORT_W-1:0];
				CFG_ZERO_HIGH:  zero_high  = vals[i][SHORT_W-1:0];
				CFG_ONE_HIGH:   one_high   = vals[i][SHORT_W-1:0];
				CFG_BIT_LOW:    bit_low    = vals[i][SHORT_W-1:0];
				default: ;
			endcase
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Start a frame and tick it through to its end; stray starts land on random ticks
	task automatic run_frame(input logic [BYTE_W-1:0] data, input int stray_pct);
		send_beat(REQ_START, data);
		while (tx_phase != PH_IDLE) begin
			if ($urandom_range(0, 99) < stray_pct) send_beat(REQ_START, BYTE_W'($urandom));
			else send_beat(REQ_TICK, BYTE_W'($urandom));
		end
	endtask

	// Registers as they come out of reset
	task automatic test_reset_values();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		settings_used++;
		send_beat(REQ_TICK, 8'h00);
		run_frame(BYTE_W'($urandom), 0);
	endtask

	// All registers zero act as one tick or one pulse; starts while busy are dropped
	task automatic test_zero_registers();
		program_timing(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		send_beat(REQ_TICK, 8'hFF);
		send_beat(REQ_START, 8'h00);
		send_beat(REQ_START, 8'hFF);
		send_beat(REQ_TICK, 8'h00);
		send_beat(REQ_START, 8'hFF);
		while (tx_phase != PH_IDLE) send_beat(REQ_TICK, 8'h00);
		send_beat(REQ_TICK, 8'hFF);
	endtask

	// Random short timings, well-formed frames with stray starts and idle ticks between
	task automatic test_random_frames(input int src_pct, input int sink_pct, input int quota);
		int first;
		program_timing(8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)),
			8'($urandom_range(0, 4)), 8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
			8'($urandom_range(0, 5)), 8'($urandom_range(0, 3)));
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		first = items_sent;
		while (items_sent - first < quota) begin
			repeat ($urandom_range(0, 2)) send_beat(REQ_TICK, BYTE_W'($urandom));
			run_frame(BYTE_W'($urandom), 5);
		end
	endtask

	// Longest gap, most preamble pulses and longest pulse in one frame
	task automatic test_extreme_registers();
		program_timing(8'd255, 8'd1, 8'd31, 8'd1, 8'd1, 8'd15, 8'd1);
		src_idle_pct   = 11;
		sink_stall_pct = 11;
		run_frame(8'h01, 1);
	endtask

	// Compare each line beat with the oldest booked one; watch for a stuck handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				beat_seen.line_level     = m_axis_tdata[0];
				beat_seen.indicator      = m_axis_tdata[1];
				beat_seen.busy           = m_axis_tdata[2];
				beat_seen.start_accepted = m_axis_tdata[3];
				beat_seen.frame_done     = m_axis_tlast;
				if (line_beats_due.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: unexpected beat: expected none, actual %b",
							$time, beat_seen);
				end else begin
					beat_due = line_beats_due.pop_front();
					check_field("line_level", beat_due.line_level, beat_seen.line_level);
					check_field("indicator", beat_due.indicator, beat_seen.indicator);
					check_field("busy", beat_due.busy, beat_seen.busy);
					check_field("frame_done", beat_due.frame_done, beat_seen.frame_done);
					check_field("start_accepted", beat_due.start_accepted,
						beat_seen.start_accepted);
					results_checked++;
				end
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles, %0d results outstanding",
					$time, STALL_LIMIT, line_beats_due.size());
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_zero_registers();
		test_random_frames(0, 0, 30);
		test_random_frames(78, 0, 30);
		test_random_frames(0, 78, 30);
		test_random_frames(11, 11, 30);
		test_extreme_registers();
		drain_results();
		$display("Sent %0d beats and checked %0d line beats: %0d frames, %0d starts refused.",
			items_sent, results_checked, frames_started, starts_ignored);
		$display("Timing settings exercised: %0d, from all zero up to field tops, %0d mismatches.",
			settings_used, mismatches);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
